@@ design/rhc_pkg.sv @@
package rhc_pkg;
  localparam int NUM_STAGES = 18;
  localparam int QDIV_BITS = 17;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] SAT_Q16 = 16'hFFFF;
  localparam logic FUNC_FWD = 1'b0;
  localparam logic FUNC_INV = 1'b1;
endpackage

@@ design/rgb_hsv_converter_core.sv @@
// rgb <-> hsv pixel converter
// input channel: in_valid/in_ready carry one request with func, the rgb or hsv
// fields and alpha; output channel: out_valid/out_ready carry one result.
// func 0: rgb codes to q0.16 hue, saturation and value
// func 1: q0.16 hsv to 8-bit codes, six-sector rule
// throughput: one request per clock unless the receiver stalls; NUM_STAGES (18)
// register stages lie between an accepted request and its result on out_valid.
// the depth is set by the two restoring dividers (hue and saturation) which
// produce one quotient bit per stage; the inverse path rides the same stages.
// the whole pipe advances when the last stage is empty or being taken, so a
// stall at the receiver freezes every stage; nothing is lost or repeated.
// in_ready is low only while the last stage holds a result that is not taken.
// reset: synchronous on rst, clears all valid bits; payload is not reset.
module rgb_hsv_converter_core
  import rhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [15:0] in_hue,
  input  logic [15:0] in_sat,
  input  logic [15:0] in_val,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [15:0] out_hue,
  output logic [15:0] out_sat,
  output logic [15:0] out_val,
  output logic [7:0]  out_alpha
);

  // per-stage state; dividers: remainder, divisor, quotient
  typedef struct packed {
    logic        fn;
    logic [7:0]  alpha;
    logic [7:0]  mx;
    logic [11:0] srem;  // saturation remainder
    logic [7:0]  sdiv;
    logic [16:0] squo;
    logic [11:0] hrem;  // hue remainder
    logic [10:0] hdiv;
    logic [16:0] hquo;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
  } stage_t;

  localparam int NDIV = QDIV_BITS;  // division steps
  // divider stage that picks up the inverse codes
  localparam int INV_TAP = 4;
  // stage 0: min/max and operands, stages 1..17: division steps
  stage_t      st [NDIV+1];
  logic        vld [NDIV+1];
  logic        adv;

  assign adv      = !vld[NDIV] || out_ready;
  assign in_ready = adv;

  // inverse path registers, in parallel with dividers
  logic [15:0] iv_v, iv_s, iv_f;
  logic [2:0]  iv_sec;
  logic [31:0] iv_sf, iv_sg;
  logic [15:0] iv_v1;
  logic [2:0]  iv_sec1;
  logic        iv_zs1;
  logic [16:0] iv_pa, iv_qa, iv_ta;
  logic [15:0] iv_v2;
  logic [2:0]  iv_sec2;
  logic        iv_zs2;
  logic [32:0] iv_pm, iv_qm, iv_tm;
  logic [15:0] iv_v3;
  logic [2:0]  iv_sec3;
  logic        iv_zs3;
  logic [7:0]  iv_r, iv_g, iv_b;

  // front end: max/min and forward operands
  logic [7:0]  mx0, mn0, c0;
  logic [18:0] h6;
  logic [10:0] tnum;
  stage_t      st_in;
  always_comb begin
    mx0 = in_red;
    if (in_green > mx0) mx0 = in_green;
    if (in_blue > mx0) mx0 = in_blue;
    mn0 = in_red;
    if (in_green < mn0) mn0 = in_green;
    if (in_blue < mn0) mn0 = in_blue;
    c0 = mx0 - mn0;
    if (mx0 == in_red) begin
      if (in_green >= in_blue) tnum = {3'd0, in_green - in_blue};
      else tnum = 11'(6 * c0) - {3'd0, in_blue - in_green};
    end else if (mx0 == in_green) begin
      tnum = 11'(2 * c0) + {3'd0, in_blue} - {3'd0, in_red};
    end else begin
      tnum = 11'(4 * c0) + {3'd0, in_red} - {3'd0, in_green};
    end
    h6 = {3'd0, in_hue} * 19'd6;
    // dividends C<<16 and T<<16: the top quotient bits are zero, so the
    // remainder starts at C or T over two and one bit is left to shift
    st_in.fn    = func;
    st_in.alpha = in_alpha;
    st_in.mx    = mx0;
    st_in.srem  = {5'd0, c0[7:1]};
    st_in.sdiv  = mx0;
    st_in.squo  = {c0[0], 16'd0};
    st_in.hrem  = {2'd0, tnum[10:1]};
    st_in.hdiv  = 11'(6 * c0);
    st_in.hquo  = {tnum[0], 16'd0};
    st_in.r8    = '0;
    st_in.g8    = '0;
    st_in.b8    = '0;
  end

  // stage 0 register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
    if (adv) begin
      st[0]  <= st_in;
      iv_v   <= in_val;
      iv_s   <= in_sat;
      iv_f   <= h6[15:0];
      iv_sec <= h6[18:16];
    end
  end

  // one restoring step per stage: the next dividend bit leaves the top of
  // squo/hquo while the new quotient bit enters below
  genvar k;
  generate
    for (k = 0; k < NDIV; k++) begin : g_div
      logic [12:0] sr_t, hr_t;
      logic [11:0] sr_n, hr_n;
      logic        sb, hb;
      stage_t      nx;
      always_comb begin
        sr_t = {st[k].srem, st[k].squo[16]} - {5'd0, st[k].sdiv};
        sb   = !sr_t[12];
        sr_n = sb ? sr_t[11:0] : {st[k].srem[10:0], st[k].squo[16]};
        hr_t = {st[k].hrem, st[k].hquo[16]} - {2'd0, st[k].hdiv};
        hb   = !hr_t[12];
        hr_n = hb ? hr_t[11:0] : {st[k].hrem[10:0], st[k].hquo[16]};
        nx      = st[k];
        nx.srem = sr_n;
        nx.squo = {st[k].squo[15:0], sb};
        nx.hrem = hr_n;
        nx.hquo = {st[k].hquo[15:0], hb};
        if (k == INV_TAP) begin
          nx.r8 = iv_r;
          nx.g8 = iv_g;
          nx.b8 = iv_b;
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (adv) begin
          vld[k+1] <= vld[k];
        end
        if (adv) begin
          st[k+1] <= nx;
        end
      end
    end
  endgenerate

  // inverse stage a: products with s
  always_ff @(posedge clk) begin
    if (adv) begin
      iv_sf   <= {16'd0, iv_s} * {16'd0, iv_f};
      iv_sg   <= {16'd0, iv_s} * ({15'd0, ONE_Q16} - {16'd0, iv_f});
      iv_v1   <= iv_v;
      iv_sec1 <= iv_sec;
      iv_zs1  <= (iv_s == 16'd0);
      iv_pa   <= ONE_Q16 - {1'b0, iv_s};
    end
  end
  // inverse stage b: complements
  logic [16:0] iv_pa1;
  always_ff @(posedge clk) begin
    if (adv) begin
      iv_pa1  <= iv_pa;
      iv_qa   <= ONE_Q16 - {1'b0, iv_sf[31:16]};
      iv_ta   <= ONE_Q16 - {1'b0, iv_sg[31:16]};
      iv_v2   <= iv_v1;
      iv_sec2 <= iv_sec1;
      iv_zs2  <= iv_zs1;
    end
  end
  // inverse stage c: products with v
  always_ff @(posedge clk) begin
    if (adv) begin
      iv_pm   <= {17'd0, iv_v2} * {16'd0, iv_pa1};
      iv_qm   <= {17'd0, iv_v2} * {16'd0, iv_qa};
      iv_tm   <= {17'd0, iv_v2} * {16'd0, iv_ta};
      iv_v3   <= iv_v2;
      iv_sec3 <= iv_sec2;
      iv_zs3  <= iv_zs2;
    end
  end
  // inverse stage d: sector select, scale to code
  logic [15:0] sel_r, sel_g, sel_b, pp, qq, tt;
  logic [23:0] cr, cg, cb;
  always_comb begin
    pp = iv_pm[31:16];
    qq = iv_qm[31:16];
    tt = iv_tm[31:16];
    case (iv_sec3)
      3'd0: begin sel_r = iv_v3; sel_g = tt; sel_b = pp; end
      3'd1: begin sel_r = qq; sel_g = iv_v3; sel_b = pp; end
      3'd2: begin sel_r = pp; sel_g = iv_v3; sel_b = tt; end
      3'd3: begin sel_r = pp; sel_g = qq; sel_b = iv_v3; end
      3'd4: begin sel_r = tt; sel_g = pp; sel_b = iv_v3; end
      default: begin sel_r = iv_v3; sel_g = pp; sel_b = qq; end
    endcase
    if (iv_zs3) begin
      sel_r = iv_v3;
      sel_g = iv_v3;
      sel_b = iv_v3;
    end
    cr = {8'd0, sel_r} * 24'd255;
    cg = {8'd0, sel_g} * 24'd255;
    cb = {8'd0, sel_b} * 24'd255;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      iv_r <= cr[23:16];
      iv_g <= cg[23:16];
      iv_b <= cb[23:16];
    end
  end

  // output: saturate and zero unused fields
  stage_t last;
  assign last      = st[NDIV];
  assign out_valid = vld[NDIV];
  assign out_alpha = last.alpha;
  always_comb begin
    if (last.fn == FUNC_INV) begin
      out_red   = last.r8;
      out_green = last.g8;
      out_blue  = last.b8;
      out_hue   = '0;
      out_sat   = '0;
      out_val   = '0;
    end else begin
      out_red   = '0;
      out_green = '0;
      out_blue  = '0;
      out_val   = {last.mx, last.mx};
      if (last.mx == 8'd0) out_sat = '0;
      else out_sat = last.squo[16] ? SAT_Q16 : last.squo[15:0];
      if (last.hdiv == 11'd0) out_hue = '0;
      else out_hue = last.hquo[16] ? SAT_Q16 : last.hquo[15:0];
    end
  end
endmodule

@@ tb/sv/tb_rgb_hsv_converter_core.sv @@
`timescale 1ns / 1ps

module tb_rgb_hsv_converter_core
  import rhc_pkg::*;
();

  typedef struct packed {
    logic        fn;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] val;
    logic [7:0]  alpha;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] val;
    logic [7:0]  alpha;
  } pixel_res_t;

  localparam int STALL_LIMIT = 2000;
  localparam int QUIET_TAIL = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic [15:0] in_hue = '0, in_sat = '0, in_val = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic [15:0] out_hue, out_sat, out_val;

  pixel_req_t pending_pixels[$];
  pixel_res_t expected_pixels[$];
  int errors = 0;
  int sent_count = 0;
  int total_count = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int take_gap = 0;
  bit stim_done = 1'b0;

  rgb_hsv_converter_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // 8-bit code from a q0.16 fraction, truncated and clamped
  function automatic logic [7:0] q16_code(longint unsigned x);
    longint unsigned c;
    c = (x * 255) >> 16;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  // expected converter output for one request
  function automatic pixel_res_t convert_pixel(pixel_req_t rq);
    pixel_res_t rs;
    longint unsigned r, g, b, mx, mn, c, t, h6, sec, f, p, q, tt, v, s, x;
    rs = '0;
    rs.alpha = rq.alpha;
    if (rq.fn == FUNC_FWD) begin
      r = rq.red; g = rq.green; b = rq.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      if (mx != 0) begin
        x = (c * 65536) / mx;
        rs.sat = (x > 65535) ? SAT_Q16 : x[15:0];
      end
      if (c != 0) begin
        if (mx == r) t = (g >= b) ? (g - b) : (6 * c - (b - g));
        else if (mx == g) t = 2 * c + b - r;
        else t = 4 * c + r - g;
        x = (t * 65536) / (6 * c);
        rs.hue = (x > 65535) ? SAT_Q16 : x[15:0];
      end
      x = mx * 257;
      rs.val = x[15:0];
    end else begin
      v = rq.val; s = rq.sat;
      if (s == 0) begin
        r = v; g = v; b = v;
      end else begin
        h6 = longint'(rq.hue) * 6;
        sec = h6 >> 16;
        f = h6 & 16'hFFFF;
        p = (v * (65536 - s)) >> 16;
        q = (v * (65536 - ((s * f) >> 16))) >> 16;
        tt = (v * (65536 - ((s * (65536 - f)) >> 16))) >> 16;
        case (sec)
          0: begin r = v; g = tt; b = p; end
          1: begin r = q; g = v; b = p; end
          2: begin r = p; g = v; b = tt; end
          3: begin r = p; g = q; b = v; end
          4: begin r = tt; g = p; b = v; end
          default: begin r = v; g = p; b = q; end
        endcase
      end
      rs.red = q16_code(r);
      rs.green = q16_code(g);
      rs.blue = q16_code(b);
    end
    return rs;
  endfunction

  function automatic pixel_req_t rand_pixel();
    pixel_req_t rq;
    rq = '0;
    rq.fn = 1'($urandom_range(0, 1));
    rq.red = 8'($urandom);
    rq.green = 8'($urandom);
    rq.blue = 8'($urandom);
    rq.hue = 16'($urandom);
    rq.sat = 16'($urandom);
    rq.val = 16'($urandom);
    rq.alpha = 8'($urandom);
    // bias toward corner values now and then
    if ($urandom_range(0, 7) == 0) rq.sat = '0;
    if ($urandom_range(0, 7) == 0) rq.val = 16'hFFFF;
    if ($urandom_range(0, 7) == 0) rq.green = rq.red;
    if ($urandom_range(0, 9) == 0) rq.blue = rq.red;
    return rq;
  endfunction

  task automatic add_pixel(logic fn, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [15:0] h, logic [15:0] s, logic [15:0] v,
                           logic [7:0] a);
    pending_pixels.push_back('{fn, r, g, b, h, s, v, a});
  endtask

  // stimulus
  initial begin
    add_pixel(FUNC_FWD, 0, 0, 0, 16'h1234, 16'h5678, 16'h9abc, 8'h00);
    add_pixel(FUNC_FWD, 255, 255, 255, 0, 0, 0, 8'hff);
    add_pixel(FUNC_FWD, 255, 0, 0, 0, 0, 0, 8'h5a);
    add_pixel(FUNC_FWD, 0, 255, 0, 0, 0, 0, 8'ha5);
    add_pixel(FUNC_FWD, 0, 0, 255, 0, 0, 0, 8'h01);
    add_pixel(FUNC_FWD, 255, 0, 1, 0, 0, 0, 8'h80);
    add_pixel(FUNC_FWD, 200, 200, 10, 0, 0, 0, 8'h7f);
    add_pixel(FUNC_FWD, 10, 200, 200, 0, 0, 0, 8'h11);
    add_pixel(FUNC_FWD, 1, 0, 0, 0, 0, 0, 8'h22);
    add_pixel(FUNC_FWD, 128, 128, 128, 0, 0, 0, 8'h33);
    add_pixel(FUNC_INV, 8'hff, 8'hff, 8'hff, 0, 0, 0, 8'h44);
    add_pixel(FUNC_INV, 0, 0, 0, 16'h4000, 0, 16'hffff, 8'h55);
    add_pixel(FUNC_INV, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff, 8'h66);
    add_pixel(FUNC_INV, 0, 0, 0, 0, 16'hffff, 16'hffff, 8'h77);
    add_pixel(FUNC_INV, 0, 0, 0, 16'h2aab, 16'hffff, 16'hffff, 8'h88);
    add_pixel(FUNC_INV, 0, 0, 0, 16'h5555, 16'h8000, 16'hffff, 8'h99);
    add_pixel(FUNC_INV, 0, 0, 0, 16'h8000, 16'hffff, 16'h8000, 8'haa);
    add_pixel(FUNC_INV, 0, 0, 0, 16'haaab, 16'h0001, 16'hffff, 8'hbb);
    add_pixel(FUNC_INV, 0, 0, 0, 16'hd555, 16'hffff, 16'hffff, 8'hcc);
    add_pixel(FUNC_INV, 0, 0, 0, 16'hc000, 16'h7fff, 16'h0000, 8'hdd);
    repeat (1100) pending_pixels.push_back(rand_pixel());
    total_count = pending_pixels.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // request driver
  always @(posedge clk) begin
    pixel_req_t rq;
    if (!rst) begin
      if (in_valid && in_ready) sent_count <= sent_count + 1;
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          if (pending_pixels.size() > 150 && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 6);
            in_valid <= 1'b0;
          end else begin
            rq = pending_pixels.pop_front();
            expected_pixels.push_back(convert_pixel(rq));
            in_valid <= 1'b1;
            func <= rq.fn;
            in_red <= rq.red;
            in_green <= rq.green;
            in_blue <= rq.blue;
            in_hue <= rq.hue;
            in_sat <= rq.sat;
            in_val <= rq.val;
            in_alpha <= rq.alpha;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap <= take_gap - 1;
      out_ready <= 1'b0;
    end else if (sent_count < total_count - 150 && $urandom_range(0, 9) == 0) begin
      take_gap <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    pixel_res_t ex;
    int bad;
    bad = 0;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no request outstanding");
        bad++;
      end else begin
        ex = expected_pixels.pop_front();
        if (out_red !== ex.red) begin
          $error("out_red expected %0d actual %0d", ex.red, out_red);
          bad++;
        end
        if (out_green !== ex.green) begin
          $error("out_green expected %0d actual %0d", ex.green, out_green);
          bad++;
        end
        if (out_blue !== ex.blue) begin
          $error("out_blue expected %0d actual %0d", ex.blue, out_blue);
          bad++;
        end
        if (out_hue !== ex.hue) begin
          $error("out_hue expected %0d actual %0d", ex.hue, out_hue);
          bad++;
        end
        if (out_sat !== ex.sat) begin
          $error("out_sat expected %0d actual %0d", ex.sat, out_sat);
          bad++;
        end
        if (out_val !== ex.val) begin
          $error("out_val expected %0d actual %0d", ex.val, out_val);
          bad++;
        end
        if (out_alpha !== ex.alpha) begin
          $error("out_alpha expected %0d actual %0d", ex.alpha, out_alpha);
          bad++;
        end
      end
    end
    if (bad > 0) errors <= errors + bad;
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (!stim_done && quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (!rst);
    while (sent_count != total_count || expected_pixels.size() != 0) @(posedge clk);
    stim_done = 1'b1;
    repeat (QUIET_TAIL) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
